// ===== src/evh_pkg.sv =====
// Shared widths, register indexes, operation codes and types of the event pixel histogram.
package evh_pkg;

    localparam int CFG_W   = 11;
    localparam int COORD_W = 16;
    localparam int RIDX_W  = 20;
    localparam int COUNT_W = 8;
    localparam int PROD_W  = 2 * CFG_W;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RESET_FRAME = CFG_W'(1024);

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // memory operation of one item
    typedef logic [1:0] t_op;
    localparam t_op OP_NONE    = 2'd0;
    localparam t_op OP_INC     = 2'd1;
    localparam t_op OP_RD_HIT  = 2'd2;
    localparam t_op OP_RD_MISS = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_res;

endpackage

// ===== src/evh_if.sv =====
// Valid/ready channel interfaces for event items and count results.
interface evh_in_if import evh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic [RIDX_W-1:0]  read_index;

    modport source (output valid, mode, event_x, event_y, read_index, input ready);
    modport sink   (input valid, mode, event_x, event_y, read_index, output ready);
endinterface

interface evh_out_if import evh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] pixel_count;

    modport source (output valid, pixel_count, input ready);
    modport sink   (input valid, pixel_count, output ready);
endinterface

// ===== src/evh_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read returns old data).
module evh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/evh_index.sv =====
// Item capture, frame and read index bounds checks and row-major address computation.
module evh_index import evh_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int Depth = MAX_WIDTH * MAX_HEIGHT,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_take,
    input  logic               i_mode,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [RIDX_W-1:0]  i_ridx,
    input  logic [CFG_W-1:0]   i_act_w,
    input  logic [CFG_W-1:0]   i_act_h,
    input  logic [PROD_W-1:0]  i_area,
    output t_op                o_op,
    output logic [AddrW-1:0]   o_addr
);

    logic               r_s1_valid;
    logic               r_s1_mode;
    logic [COORD_W-1:0] r_s1_x;
    logic [COORD_W-1:0] r_s1_y;
    logic [RIDX_W-1:0]  r_s1_ridx;
    t_op                r_s2_op;
    logic [AddrW-1:0]   r_s2_addr;

    logic              x_in;
    logic              y_in;
    logic              rd_hit;
    logic [PROD_W-1:0] ev_idx;
    t_op               n_op;
    logic [AddrW-1:0]  n_addr;

    always_comb begin
        x_in   = !r_s1_x[COORD_W-1] && (r_s1_x < COORD_W'(i_act_w));
        y_in   = !r_s1_y[COORD_W-1] && (r_s1_y < COORD_W'(i_act_h));
        // y < height <= 2047 here, so the low bits carry the whole row
        ev_idx = PROD_W'(r_s1_y[CFG_W-1:0]) * PROD_W'(i_act_w)
               + PROD_W'(r_s1_x[CFG_W-1:0]);
        rd_hit = PROD_W'(r_s1_ridx) < i_area;
        if (!r_s1_valid) begin
            n_op = OP_NONE;
        end else if (r_s1_mode) begin
            n_op = rd_hit ? OP_RD_HIT : OP_RD_MISS;
        end else begin
            n_op = (x_in && y_in) ? OP_INC : OP_NONE;
        end
        n_addr = r_s1_mode ? AddrW'(r_s1_ridx) : AddrW'(ev_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_op    <= OP_NONE;
        end else if (i_adv) begin
            r_s1_valid <= i_take;
            r_s2_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_mode <= i_mode;
            r_s1_x    <= i_x;
            r_s1_y    <= i_y;
            r_s1_ridx <= i_ridx;
            r_s2_addr <= n_addr;
        end
    end

    assign o_op   = r_s2_op;
    assign o_addr = r_s2_addr;

endmodule

// ===== src/evh_update.sv =====
// Count memory with read-modify-write, write forwarding and the clearing pass after reset.
module evh_update import evh_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int Depth = MAX_WIDTH * MAX_HEIGHT,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_op              i_op,
    input  logic [AddrW-1:0] i_addr,
    output t_res             o_res,
    output logic             o_clearing
);

    t_op                r_s3_op;
    logic [AddrW-1:0]   r_s3_addr;
    logic               r_wb_valid;
    logic [AddrW-1:0]   r_wb_addr;
    logic [COUNT_W-1:0] r_wb_data;
    logic               r_clearing;
    logic [AddrW-1:0]   r_clr_addr;

    logic [COUNT_W-1:0] rd_data;
    logic [COUNT_W-1:0] cur;
    logic [AddrW-1:0]   rd_addr;
    logic               op_we;
    logic [COUNT_W-1:0] op_wdata;
    logic               ram_we;
    logic [AddrW-1:0]   ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;

    // re-read the held entry while stalled so the read data stays aligned with stage 3
    assign rd_addr = i_adv ? i_addr : r_s3_addr;

    evh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (Depth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        // the write at the same edge as the read is not in the read data: forward it
        cur = (r_wb_valid && (r_wb_addr == r_s3_addr)) ? r_wb_data : rd_data;
        op_we    = 1'b0;
        op_wdata = '0;
        o_res    = '0;
        case (r_s3_op)
            OP_INC: begin
                op_we    = i_adv;
                op_wdata = cur + COUNT_W'(1);
            end
            OP_RD_HIT: begin
                op_we       = i_adv;
                o_res.valid = 1'b1;
                o_res.count = cur;
            end
            OP_RD_MISS: begin
                o_res.valid = 1'b1;
            end
            default: begin
                op_we = 1'b0;
            end
        endcase
        ram_we    = r_clearing || op_we;
        ram_waddr = r_clearing ? r_clr_addr : r_s3_addr;
        ram_wdata = r_clearing ? '0 : op_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_op    <= OP_NONE;
            r_wb_valid <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_adv) begin
                r_s3_op <= i_op;
            end
            if (op_we) begin
                r_wb_valid <= 1'b1;
            end
            if (r_clearing) begin
                if (r_clr_addr == AddrW'(Depth - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AddrW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3_addr <= i_addr;
        end
        if (op_we) begin
            r_wb_addr <= r_s3_addr;
            r_wb_data <= op_wdata;
        end
    end

    assign o_clearing = r_clearing;

endmodule

// ===== src/event_pixel_histogram.sv =====
// Top level of the event pixel histogram: configuration, pipeline control and result register.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+--------------------------------------------
//  i_evt     | in  | valid/ready      | mode, event_x, event_y, read_index
//  o_cnt     | out | valid/ready      | pixel_count (one per read item)
//  i_cfg_*   | in  | write enable     | index 0 frame_width, 1 frame_height
//
// One item per cycle, while not stalled or clearing, enters a four-stage path: capture,
// bounds check and address multiply, memory read, then modify and write back with
// forwarding of the last write. o_cnt.valid rises once a read item's result is loaded
// into the result register. After reset a clearing pass writes zero to every count
// while i_evt.ready stays low. A stalled result with another read behind it holds
// the whole path until o_cnt is taken.
module event_pixel_histogram import evh_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int Depth = MAX_WIDTH * MAX_HEIGHT,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    evh_in_if.sink           i_evt,
    evh_out_if.source        o_cnt,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] v, input int lim);
        sat_dim = (int'(v) > lim) ? CFG_W'(lim) : v;
    endfunction

    logic [CFG_W-1:0]   r_act_w;
    logic [CFG_W-1:0]   r_act_h;
    logic [PROD_W-1:0]  r_area;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    logic             stall;
    logic             adv;
    logic             take;
    logic             clearing;
    t_op              s2_op;
    logic [AddrW-1:0] s2_addr;
    t_res             res;

    assign stall = res.valid && r_out_valid && !o_cnt.ready;
    assign adv   = !stall;

    assign i_evt.ready = adv && !clearing;
    assign take        = i_evt.valid && i_evt.ready;

    evh_index #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_take  (take),
        .i_mode  (i_evt.mode),
        .i_x     (i_evt.event_x),
        .i_y     (i_evt.event_y),
        .i_ridx  (i_evt.read_index),
        .i_act_w (r_act_w),
        .i_act_h (r_act_h),
        .i_area  (r_area),
        .o_op    (s2_op),
        .o_addr  (s2_addr)
    );

    evh_update #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_op       (s2_op),
        .i_addr     (s2_addr),
        .o_res      (res),
        .o_clearing (clearing)
    );

    // saturate at write time; the area is registered from the saturated width and height
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w     <= sat_dim(RESET_FRAME, MAX_WIDTH);
            r_act_h     <= sat_dim(RESET_FRAME, MAX_HEIGHT);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_act_w <= sat_dim(i_cfg_data, MAX_WIDTH);
                    CFG_FRAME_HEIGHT: r_act_h <= sat_dim(i_cfg_data, MAX_HEIGHT);
                    default: begin
                        r_act_w <= r_act_w;
                    end
                endcase
            end
            if (res.valid && adv) begin
                r_out_valid <= 1'b1;
            end else if (o_cnt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= PROD_W'(r_act_w) * PROD_W'(r_act_h);
        if (res.valid && adv) begin
            r_out_count <= res.count;
        end
    end

    assign o_cnt.valid       = r_out_valid;
    assign o_cnt.pixel_count = r_out_count;

endmodule
